// ----- rtl/core/ps2h_pkg.sv -----
// Package with phase codes, request codes and register constants for the PS/2 host engine.
`timescale 1ns / 1ps

package ps2h_pkg;

  // Width of the timing registers and of the transferred byte
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned BYTE_BITS = 8;

  // Request codes on func
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_SEND = 2'd1;
  localparam logic [1:0] FUNC_RECV = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_INHIBIT      = 2'd0;
  localparam logic [1:0] CFG_START_GAP    = 2'd1;
  localparam logic [1:0] CFG_RELEASE_WAIT = 2'd2;
  localparam logic [1:0] CFG_READ_SETTLE  = 2'd3;

  // Register values after reset
  localparam logic [CFG_W-1:0] INHIBIT_RST      = 12'd300;
  localparam logic [CFG_W-1:0] START_GAP_RST    = 12'd10;
  localparam logic [CFG_W-1:0] RELEASE_WAIT_RST = 12'd50;
  localparam logic [CFG_W-1:0] READ_SETTLE_RST  = 12'd5;

  // Transfer phases
  typedef enum logic [4:0] {
    PH_IDLE          = 5'd0,
    PH_TX_REL        = 5'd1,
    PH_TX_INH        = 5'd2,
    PH_TX_GAP        = 5'd3,
    PH_TX_START      = 5'd4,
    PH_TX_BIT_LOW    = 5'd5,
    PH_TX_BIT_HIGH   = 5'd6,
    PH_TX_PAR_LOW    = 5'd7,
    PH_TX_PAR_HIGH   = 5'd8,
    PH_TX_STOP_WAIT  = 5'd9,
    PH_TX_ACK_LOW    = 5'd10,
    PH_TX_ACK_END    = 5'd11,
    PH_RX_REL        = 5'd12,
    PH_RX_START_LOW  = 5'd13,
    PH_RX_SETTLE     = 5'd14,
    PH_RX_START_HIGH = 5'd15,
    PH_RX_BIT_LOW    = 5'd16,
    PH_RX_BIT_HIGH   = 5'd17,
    PH_RX_PAR_LOW    = 5'd18,
    PH_RX_PAR_HIGH   = 5'd19,
    PH_RX_STOP_LOW   = 5'd20,
    PH_RX_STOP_HIGH  = 5'd21
  } phase_t;

endpackage

// ----- rtl/core/ps2_host_byte_transfer.sv -----
// PS/2 host byte transfer engine, advanced by one sampling tick per input transfer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | to block  | in_valid / in_stall  | func, tx_byte, clk_level, data_level
//  out     | from block| out_valid / out_stall| clk_pull_low, data_pull_low, busy_res,
//          |           |                      | rx_byte, rx_done, tx_done
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One tick is taken every cycle while in_stall is low; its result appears in the output register on the next cycle.
// The phase machine and counters update in one pass between the tick input and that register.
// Reset (rst, synchronous) returns the phase to idle, clears both line holds and loads the
// timing registers with their defaults. in_stall rises only while a held result is stalled.
`timescale 1ns / 1ps

module ps2_host_byte_transfer
  import ps2h_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  // tick input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           func,
  input  logic [BYTE_BITS-1:0] tx_byte,
  input  logic                 clk_level,
  input  logic                 data_level,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 clk_pull_low,
  output logic                 data_pull_low,
  output logic                 busy_res,
  output logic [BYTE_BITS-1:0] rx_byte,
  output logic                 rx_done,
  output logic                 tx_done,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned WIDE_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Timing registers
  logic [CFG_W-1:0] inhibit_ticks;
  logic [CFG_W-1:0] start_gap_ticks;
  logic [CFG_W-1:0] release_wait_ticks;
  logic [CFG_W-1:0] read_settle_ticks;

  // Engine state
  phase_t                 phase, phase_next;
  logic [COUNT_BITS-1:0]  wait_count, wait_count_next;
  logic [3:0]             bit_count, bit_count_next;
  logic [BYTE_BITS-1:0]   shift_reg, shift_reg_next;
  logic                   parity_acc, parity_acc_next;
  logic                   clk_hold, clk_hold_next;
  logic                   data_hold, data_hold_next;
  logic [BYTE_BITS-1:0]   last_rx, last_rx_next;
  logic                   rx_done_next, tx_done_next;

  logic                   in_accept;
  logic                   wait_zero;
  logic [3:0]             bit_inc;
  logic                   more_bits;
  logic [BYTE_BITS-1:0]   tx_shifted;
  logic                   tx_parity;
  logic                   load_en;
  logic [CFG_W-1:0]       load_val;
  logic [WIDE_W-1:0]      load_wide;
  logic [COUNT_BITS-1:0]  load_sat;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign wait_zero  = (wait_count == '0);
  assign bit_inc    = bit_count + 4'd1;
  assign more_bits  = (bit_inc < 4'(BYTE_BITS));
  assign tx_shifted = shift_reg >> 1;
  assign tx_parity  = parity_acc ^ shift_reg[0];

  // Saturate a loaded wait to the counter range
  assign load_wide = WIDE_W'(load_val);
  assign load_sat  = (load_wide > WIDE_W'(CNT_MAX)) ? CNT_MAX : load_wide[COUNT_BITS-1:0];

  // Write timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inhibit_ticks      <= INHIBIT_RST;
      start_gap_ticks    <= START_GAP_RST;
      release_wait_ticks <= RELEASE_WAIT_RST;
      read_settle_ticks  <= READ_SETTLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INHIBIT:      inhibit_ticks      <= cfg_data;
        CFG_START_GAP:    start_gap_ticks    <= cfg_data;
        CFG_RELEASE_WAIT: release_wait_ticks <= cfg_data;
        CFG_READ_SETTLE:  read_settle_ticks  <= cfg_data;
        default:          inhibit_ticks      <= inhibit_ticks;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (func == FUNC_SEND) begin
          phase_next = PH_TX_REL;
        end else if (func == FUNC_RECV) begin
          phase_next = PH_RX_REL;
        end
      end
      PH_TX_REL:        if (wait_zero) phase_next = PH_TX_INH;
      PH_TX_INH:        if (wait_zero) phase_next = PH_TX_GAP;
      PH_TX_GAP:        if (wait_zero) phase_next = PH_TX_START;
      PH_TX_START:      if (!clk_level) phase_next = PH_TX_BIT_LOW;
      PH_TX_BIT_LOW:    if (clk_level) phase_next = PH_TX_BIT_HIGH;
      PH_TX_BIT_HIGH: begin
        if (!clk_level) begin
          phase_next = more_bits ? PH_TX_BIT_LOW : PH_TX_PAR_LOW;
        end
      end
      PH_TX_PAR_LOW:    if (clk_level) phase_next = PH_TX_PAR_HIGH;
      PH_TX_PAR_HIGH:   if (!clk_level) phase_next = PH_TX_STOP_WAIT;
      PH_TX_STOP_WAIT:  if (wait_zero) phase_next = PH_TX_ACK_LOW;
      PH_TX_ACK_LOW:    if (!clk_level) phase_next = PH_TX_ACK_END;
      PH_TX_ACK_END:    if (clk_level && data_level) phase_next = PH_IDLE;
      PH_RX_REL:        if (wait_zero) phase_next = PH_RX_START_LOW;
      PH_RX_START_LOW:  if (!clk_level) phase_next = PH_RX_SETTLE;
      PH_RX_SETTLE:     if (wait_zero) phase_next = PH_RX_START_HIGH;
      PH_RX_START_HIGH: if (clk_level) phase_next = PH_RX_BIT_LOW;
      PH_RX_BIT_LOW:    if (!clk_level) phase_next = PH_RX_BIT_HIGH;
      PH_RX_BIT_HIGH: begin
        if (clk_level) begin
          phase_next = more_bits ? PH_RX_BIT_LOW : PH_RX_PAR_LOW;
        end
      end
      PH_RX_PAR_LOW:    if (!clk_level) phase_next = PH_RX_PAR_HIGH;
      PH_RX_PAR_HIGH:   if (clk_level) phase_next = PH_RX_STOP_LOW;
      PH_RX_STOP_LOW:   if (!clk_level) phase_next = PH_RX_STOP_HIGH;
      PH_RX_STOP_HIGH:  if (clk_level) phase_next = PH_IDLE;
      default:          phase_next = PH_IDLE;
    endcase
  end

  // Line drives, counters and shift data
  always_comb begin
    wait_count_next = wait_count;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    parity_acc_next = parity_acc;
    clk_hold_next   = clk_hold;
    data_hold_next  = data_hold;
    last_rx_next    = last_rx;
    rx_done_next    = 1'b0;
    tx_done_next    = 1'b0;
    load_en         = 1'b0;
    load_val        = release_wait_ticks;

    // count down any timed wait that is still running
    if (!wait_zero) begin
      wait_count_next = wait_count - COUNT_BITS'(1);
    end

    unique case (phase)
      PH_IDLE: begin
        if (func == FUNC_SEND) begin
          clk_hold_next   = 1'b0;
          data_hold_next  = 1'b0;
          shift_reg_next  = tx_byte;
          parity_acc_next = 1'b1;
          bit_count_next  = '0;
          load_en         = 1'b1;
          load_val        = inhibit_ticks;
        end else if (func == FUNC_RECV) begin
          clk_hold_next   = 1'b0;
          data_hold_next  = 1'b0;
          shift_reg_next  = '0;
          bit_count_next  = '0;
          load_en         = 1'b1;
          load_val        = release_wait_ticks;
        end
      end
      PH_TX_REL: begin
        if (wait_zero) begin
          clk_hold_next = 1'b1;
          load_en       = 1'b1;
          load_val      = inhibit_ticks;
        end
      end
      PH_TX_INH: begin
        if (wait_zero) begin
          data_hold_next = 1'b1;
          load_en        = 1'b1;
          load_val       = start_gap_ticks;
        end
      end
      PH_TX_GAP: begin
        if (wait_zero) clk_hold_next = 1'b0;
      end
      PH_TX_START: begin
        if (!clk_level) data_hold_next = ~shift_reg[0];
      end
      PH_TX_BIT_HIGH: begin
        // advance to the next data bit, or present parity after the last one
        if (!clk_level) begin
          parity_acc_next = tx_parity;
          shift_reg_next  = tx_shifted;
          bit_count_next  = bit_inc;
          data_hold_next  = more_bits ? ~tx_shifted[0] : ~tx_parity;
        end
      end
      PH_TX_PAR_HIGH: begin
        if (!clk_level) begin
          data_hold_next = 1'b0;
          load_en        = 1'b1;
          load_val       = release_wait_ticks;
        end
      end
      PH_TX_ACK_END: begin
        if (clk_level && data_level) begin
          clk_hold_next = 1'b1;
          tx_done_next  = 1'b1;
        end
      end
      PH_RX_START_LOW: begin
        if (!clk_level) begin
          load_en  = 1'b1;
          load_val = read_settle_ticks;
        end
      end
      PH_RX_BIT_LOW: begin
        // sample data on the clock low
        if (!clk_level && data_level) begin
          shift_reg_next[bit_count[2:0]] = 1'b1;
        end
      end
      PH_RX_BIT_HIGH: begin
        if (clk_level) bit_count_next = bit_inc;
      end
      PH_RX_STOP_HIGH: begin
        if (clk_level) begin
          clk_hold_next = 1'b1;
          last_rx_next  = shift_reg;
          rx_done_next  = 1'b1;
        end
      end
      default: begin
        clk_hold_next = clk_hold;
      end
    endcase

    if (load_en) begin
      wait_count_next = load_sat;
    end
  end

  // Advance engine state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      wait_count <= '0;
      bit_count  <= '0;
      shift_reg  <= '0;
      parity_acc <= 1'b1;
      clk_hold   <= 1'b0;
      data_hold  <= 1'b0;
      last_rx    <= '0;
    end else if (in_accept) begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      parity_acc <= parity_acc_next;
      clk_hold   <= clk_hold_next;
      data_hold  <= data_hold_next;
      last_rx    <= last_rx_next;
    end
  end

  // Hold the result until the output transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      clk_pull_low  <= clk_hold_next;
      data_pull_low <= data_hold_next;
      busy_res      <= (phase_next != PH_IDLE);
      rx_byte       <= last_rx_next;
      rx_done       <= rx_done_next;
      tx_done       <= tx_done_next;
    end
  end

endmodule
